/* src/eulp_pkg.sv */
// shared types, codes and the microprogram of the euler left eigen projection block
package eulp_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int GAMMA_W = 18;
  localparam int ACC_W   = 64;
  localparam int PC_W    = 6;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_INVALID   = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic [PC_W-1:0] LOAD_START = 6'd0;
  localparam logic [PC_W-1:0] PROJ_START = 6'd22;

  typedef struct packed {
    logic               command;
    logic               direction;
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] total_energy;
  } in_t;

  typedef struct packed {
    logic signed [31:0] wave_first;
    logic signed [31:0] wave_second;
    logic signed [31:0] wave_third;
    logic signed [31:0] wave_fourth;
    logic signed [31:0] wave_fifth;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [1:0] {K_ALU, K_MUL, K_DIV, K_SQRT} kind_t;

  typedef enum logic [2:0] {AOP_LD, AOP_ADD, AOP_SUB, AOP_HNEG, AOP_DBL} aop_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_Q1, SRC_QN, SRC_QT, SRC_QZ, SRC_Q5,
    SRC_U1, SRC_U2, SRC_U3, SRC_Q2, SRC_HQ, SRC_C, SRC_H, SRC_RD, SRC_RDS,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_G, SRC_GM1
  } src_t;

  typedef enum logic [4:0] {
    DST_NONE, DST_U1, DST_U2, DST_U3, DST_Q2, DST_C, DST_H, DST_RD, DST_RDS,
    DST_T0, DST_T1, DST_T2, DST_T3, DST_W1, DST_W5, DST_WE, DST_WT, DST_WZ
  } dst_t;

  typedef enum logic [1:0] {CHK_NONE, CHK_LE0, CHK_EQ0} chk_t;

  typedef struct packed {
    kind_t kind;
    aop_t  aop;
    src_t  src_a;
    src_t  src_b;
    dst_t  dst;
    chk_t  chk;
    logic  last;
  } uop_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul_go;
    logic unit_go;
    logic commit;
    logic out_load;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic avg_valid;
    logic unit_done;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MACC  = 5'b00100,
    ST_UNIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  function automatic uop_t mk(input kind_t k, input aop_t a, input src_t sa, input src_t sb,
                              input dst_t d, input chk_t c, input logic l);
    uop_t u;
    u.kind  = k;
    u.aop   = a;
    u.src_a = sa;
    u.src_b = sb;
    u.dst   = d;
    u.chk   = c;
    u.last  = l;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // load: derive the average state
      6'd0:  u = mk(K_ALU,  AOP_LD,   SRC_Q1,   SRC_ZERO, DST_NONE, CHK_LE0,  1'b0);
      6'd1:  u = mk(K_DIV,  AOP_LD,   SRC_QN,   SRC_Q1,   DST_U1,   CHK_NONE, 1'b0);
      6'd2:  u = mk(K_DIV,  AOP_LD,   SRC_QT,   SRC_Q1,   DST_U2,   CHK_NONE, 1'b0);
      6'd3:  u = mk(K_DIV,  AOP_LD,   SRC_QZ,   SRC_Q1,   DST_U3,   CHK_NONE, 1'b0);
      6'd4:  u = mk(K_MUL,  AOP_LD,   SRC_U1,   SRC_U1,   DST_NONE, CHK_NONE, 1'b0);
      6'd5:  u = mk(K_MUL,  AOP_ADD,  SRC_U2,   SRC_U2,   DST_NONE, CHK_NONE, 1'b0);
      6'd6:  u = mk(K_MUL,  AOP_ADD,  SRC_U3,   SRC_U3,   DST_Q2,   CHK_NONE, 1'b0);
      6'd7:  u = mk(K_MUL,  AOP_LD,   SRC_Q1,   SRC_Q2,   DST_NONE, CHK_NONE, 1'b0);
      6'd8:  u = mk(K_ALU,  AOP_HNEG, SRC_ZERO, SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd9:  u = mk(K_ALU,  AOP_ADD,  SRC_Q5,   SRC_ZERO, DST_T0,   CHK_NONE, 1'b0);
      6'd10: u = mk(K_MUL,  AOP_LD,   SRC_GM1,  SRC_T0,   DST_T1,   CHK_LE0,  1'b0);
      6'd11: u = mk(K_MUL,  AOP_LD,   SRC_G,    SRC_T1,   DST_T2,   CHK_NONE, 1'b0);
      6'd12: u = mk(K_DIV,  AOP_LD,   SRC_T2,   SRC_Q1,   DST_T3,   CHK_LE0,  1'b0);
      6'd13: u = mk(K_SQRT, AOP_LD,   SRC_T3,   SRC_ZERO, DST_C,    CHK_NONE, 1'b0);
      6'd14: u = mk(K_ALU,  AOP_LD,   SRC_Q5,   SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd15: u = mk(K_ALU,  AOP_ADD,  SRC_T1,   SRC_ZERO, DST_T2,   CHK_NONE, 1'b0);
      6'd16: u = mk(K_DIV,  AOP_LD,   SRC_T2,   SRC_Q1,   DST_H,    CHK_NONE, 1'b0);
      6'd17: u = mk(K_ALU,  AOP_LD,   SRC_H,    SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd18: u = mk(K_ALU,  AOP_DBL,  SRC_ZERO, SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd19: u = mk(K_ALU,  AOP_SUB,  SRC_Q2,   SRC_ZERO, DST_T0,   CHK_EQ0,  1'b0);
      6'd20: u = mk(K_DIV,  AOP_LD,   SRC_ONE,  SRC_T0,   DST_RD,   CHK_NONE, 1'b0);
      6'd21: u = mk(K_DIV,  AOP_LD,   SRC_RD,   SRC_C,    DST_RDS,  CHK_NONE, 1'b1);
      // project: entropy-like sum s
      6'd22: u = mk(K_ALU,  AOP_LD,   SRC_Q5,   SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd23: u = mk(K_MUL,  AOP_SUB,  SRC_U2,   SRC_QT,   DST_NONE, CHK_NONE, 1'b0);
      6'd24: u = mk(K_MUL,  AOP_SUB,  SRC_U3,   SRC_QZ,   DST_T0,   CHK_NONE, 1'b0);
      // left acoustic wave
      6'd25: u = mk(K_ALU,  AOP_LD,   SRC_HQ,   SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd26: u = mk(K_ALU,  AOP_SUB,  SRC_H,    SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd27: u = mk(K_MUL,  AOP_SUB,  SRC_U1,   SRC_C,    DST_T1,   CHK_NONE, 1'b0);
      6'd28: u = mk(K_ALU,  AOP_LD,   SRC_C,    SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd29: u = mk(K_ALU,  AOP_SUB,  SRC_U1,   SRC_ZERO, DST_T2,   CHK_NONE, 1'b0);
      6'd30: u = mk(K_MUL,  AOP_LD,   SRC_HQ,   SRC_T2,   DST_NONE, CHK_NONE, 1'b0);
      6'd31: u = mk(K_MUL,  AOP_ADD,  SRC_H,    SRC_U1,   DST_T2,   CHK_NONE, 1'b0);
      6'd32: u = mk(K_MUL,  AOP_LD,   SRC_T1,   SRC_QN,   DST_NONE, CHK_NONE, 1'b0);
      6'd33: u = mk(K_MUL,  AOP_ADD,  SRC_T2,   SRC_Q1,   DST_NONE, CHK_NONE, 1'b0);
      6'd34: u = mk(K_MUL,  AOP_ADD,  SRC_C,    SRC_T0,   DST_T1,   CHK_NONE, 1'b0);
      6'd35: u = mk(K_MUL,  AOP_LD,   SRC_T1,   SRC_RDS,  DST_W1,   CHK_NONE, 1'b0);
      // right acoustic wave
      6'd36: u = mk(K_ALU,  AOP_LD,   SRC_H,    SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd37: u = mk(K_ALU,  AOP_SUB,  SRC_HQ,   SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd38: u = mk(K_MUL,  AOP_SUB,  SRC_U1,   SRC_C,    DST_T1,   CHK_NONE, 1'b0);
      6'd39: u = mk(K_ALU,  AOP_LD,   SRC_C,    SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd40: u = mk(K_ALU,  AOP_ADD,  SRC_U1,   SRC_ZERO, DST_T2,   CHK_NONE, 1'b0);
      6'd41: u = mk(K_MUL,  AOP_LD,   SRC_HQ,   SRC_T2,   DST_NONE, CHK_NONE, 1'b0);
      6'd42: u = mk(K_MUL,  AOP_SUB,  SRC_H,    SRC_U1,   DST_T2,   CHK_NONE, 1'b0);
      6'd43: u = mk(K_MUL,  AOP_LD,   SRC_T1,   SRC_QN,   DST_NONE, CHK_NONE, 1'b0);
      6'd44: u = mk(K_MUL,  AOP_ADD,  SRC_T2,   SRC_Q1,   DST_NONE, CHK_NONE, 1'b0);
      6'd45: u = mk(K_MUL,  AOP_ADD,  SRC_C,    SRC_T0,   DST_T1,   CHK_NONE, 1'b0);
      6'd46: u = mk(K_MUL,  AOP_LD,   SRC_T1,   SRC_RDS,  DST_W5,   CHK_NONE, 1'b0);
      // entropy wave
      6'd47: u = mk(K_ALU,  AOP_LD,   SRC_H,    SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd48: u = mk(K_ALU,  AOP_SUB,  SRC_Q2,   SRC_ZERO, DST_T1,   CHK_NONE, 1'b0);
      6'd49: u = mk(K_MUL,  AOP_LD,   SRC_T1,   SRC_Q1,   DST_NONE, CHK_NONE, 1'b0);
      6'd50: u = mk(K_MUL,  AOP_ADD,  SRC_U1,   SRC_QN,   DST_NONE, CHK_NONE, 1'b0);
      6'd51: u = mk(K_MUL,  AOP_ADD,  SRC_U2,   SRC_QT,   DST_NONE, CHK_NONE, 1'b0);
      6'd52: u = mk(K_MUL,  AOP_ADD,  SRC_U3,   SRC_QZ,   DST_NONE, CHK_NONE, 1'b0);
      6'd53: u = mk(K_ALU,  AOP_SUB,  SRC_Q5,   SRC_ZERO, DST_T1,   CHK_NONE, 1'b0);
      6'd54: u = mk(K_MUL,  AOP_LD,   SRC_T1,   SRC_RD,   DST_NONE, CHK_NONE, 1'b0);
      6'd55: u = mk(K_ALU,  AOP_DBL,  SRC_ZERO, SRC_ZERO, DST_WE,   CHK_NONE, 1'b0);
      // shear waves
      6'd56: u = mk(K_ALU,  AOP_LD,   SRC_QT,   SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd57: u = mk(K_MUL,  AOP_SUB,  SRC_U2,   SRC_Q1,   DST_WT,   CHK_NONE, 1'b0);
      6'd58: u = mk(K_ALU,  AOP_LD,   SRC_QZ,   SRC_ZERO, DST_NONE, CHK_NONE, 1'b0);
      6'd59: u = mk(K_MUL,  AOP_SUB,  SRC_U3,   SRC_Q1,   DST_WZ,   CHK_NONE, 1'b1);
      default: u = mk(K_ALU, AOP_LD,  SRC_ZERO, SRC_ZERO, DST_NONE, CHK_NONE, 1'b1);
    endcase
    return u;
  endfunction

endpackage

/* src/euler_left_eigen_projection.sv */
// top level of the euler left eigenvector projection block
// A load word (command 0) takes a cell-average conserved state and a sweep
// direction and keeps the derived velocities, sound speed, enthalpy and two
// reciprocal denominators; it gives no result. Each project word (command 1)
// gives one result word with the five characteristic components in storage
// order, status 1 if the last load was not a valid state and status 2 if any
// step that writes a register saturated. Everything runs through a
// microprogram over one shared 32x32 multiplier with a 64-bit accumulator:
// a project word is accepted, runs 23 products and 15 add steps, each product
// issued to the multiplier and then accumulated, and then loads the output
// register. A load word passes seven times through the bit-serial divider
// and once through the two-bits-per-cycle square root unit. A new word is
// accepted while the previous result still waits in the output register.
module euler_left_eigen_projection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  eulp_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output eulp_pkg::out_t                out_data,
  input  logic                          cfg_wr_en,
  input  logic [eulp_pkg::GAMMA_W-1:0]  cfg_wr_data
);
  import eulp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  eulp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  eulp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

/* src/eulp_div.sv */
// bit-serial signed fixed-point divider, quotient truncated toward zero
module eulp_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [31:0]             num,
  input  logic signed [31:0]             den,
  output logic                           done,
  output logic signed [32+FRACTION_BITS:0] quot
);
  import eulp_pkg::*;

  localparam int NW = 32 + FRACTION_BITS;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] shf_r;
  logic [31:0]   den_r;
  logic [31:0]   rem_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [32:0]   rem_sh;
  logic [32:0]   diff;
  logic          qbit;
  logic [31:0]   num_mag;
  logic [31:0]   den_mag;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh  = {rem_r, shf_r[NW-1]};
  assign diff    = rem_sh - {1'b0, den_r};
  assign qbit    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      shf_r <= {num_mag, {FRACTION_BITS{1'b0}}};
      den_r <= den_mag;
      rem_r <= '0;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r) begin
      rem_r <= qbit ? diff[31:0] : rem_sh[31:0];
      shf_r <= {shf_r[NW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, shf_r}) : $signed({1'b0, shf_r});

endmodule

/* src/eulp_sqrt.sv */
// digit-by-digit integer square root of a value scaled up by the fraction bits
module eulp_sqrt #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [31:0]                                  rad,
  output logic                                         done,
  output logic [(32+FRACTION_BITS+((32+FRACTION_BITS)%2))/2-1:0] root
);
  import eulp_pkg::*;

  localparam int RW = 32 + FRACTION_BITS;
  localparam int SW = RW + (RW % 2);
  localparam int HW = SW / 2;
  localparam int CW = $clog2(HW);

  logic [SW-1:0]   rad_r;
  logic [HW+1:0]   rem_r;
  logic [HW-1:0]   root_r;
  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [HW+2:0]   rem_sh;
  logic [HW+2:0]   trial;
  logic            rbit;

  assign rem_sh = {rem_r[HW:0], rad_r[SW-1:SW-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign rbit   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(HW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= SW'({rad, {FRACTION_BITS{1'b0}}});
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rbit ? (HW+2)'(rem_sh - trial) : (HW+2)'(rem_sh);
      root_r <= {root_r[HW-2:0], rbit};
      rad_r  <= {rad_r[SW-3:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* src/eulp_datapath.sv */
// datapath: input and state registers, shared multiplier, accumulator, divide and sqrt units
module eulp_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eulp_pkg::in_t                 in_data,
  input  eulp_pkg::cmd_t                cmd,
  output eulp_pkg::sts_t                sts,
  input  logic                          cfg_wr_en,
  input  logic [eulp_pkg::GAMMA_W-1:0]  cfg_wr_data,
  output eulp_pkg::out_t                out_data
);
  import eulp_pkg::*;

  localparam int NW = 32 + FRACTION_BITS;
  localparam int RW = 32 + FRACTION_BITS;
  localparam int HW = (RW + (RW % 2)) / 2;
  localparam logic signed [31:0] FX_ONE = 32'(64'd1 << FRACTION_BITS);
  localparam logic signed [ACC_W-1:0] FX_HALF = ACC_W'(64'd1 << (FRACTION_BITS - 1));
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'((64'd7 << FRACTION_BITS) / 5);
  localparam logic signed [ACC_W-1:0] MAX32 = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] MIN32 = -64'sd2147483648;

  logic [GAMMA_W-1:0]       gamma_r;
  logic                     sweep_r;
  logic                     valid_r;
  logic                     bad_r;
  logic                     clamp_r;
  logic signed [31:0]       q1_r, qn_r, qt_r, qz_r, q5_r;
  logic signed [31:0]       u1_r, u2_r, u3_r, q2_r, c_r, h_r, rd_r, rds_r;
  logic signed [31:0]       t0_r, t1_r, t2_r, t3_r;
  logic signed [31:0]       w1_r, w5_r, we_r, wt_r, wz_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_r;
  out_t                     out_r;

  uop_t                     uop;
  src_t                     sel [2];
  logic signed [31:0]       opnd [2];
  logic signed [31:0]       g_val, gm1_val, hq_val;
  logic signed [ACC_W-1:0]  mres, operand, value;
  logic signed [31:0]       wval;
  logic                     clip, chk_fail, dir_l;
  logic                     div_done, sqrt_done;
  logic signed [NW:0]       div_q;
  logic [HW-1:0]            root;

  assign uop     = cmd.uop;
  assign g_val   = 32'(gamma_r);
  assign gm1_val = g_val - FX_ONE;
  assign hq_val  = q2_r >>> 1;
  assign sel[0]  = uop.src_a;
  assign sel[1]  = uop.src_b;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (sel[i])
        SRC_ZERO: opnd[i] = '0;
        SRC_ONE:  opnd[i] = FX_ONE;
        SRC_Q1:   opnd[i] = q1_r;
        SRC_QN:   opnd[i] = qn_r;
        SRC_QT:   opnd[i] = qt_r;
        SRC_QZ:   opnd[i] = qz_r;
        SRC_Q5:   opnd[i] = q5_r;
        SRC_U1:   opnd[i] = u1_r;
        SRC_U2:   opnd[i] = u2_r;
        SRC_U3:   opnd[i] = u3_r;
        SRC_Q2:   opnd[i] = q2_r;
        SRC_HQ:   opnd[i] = hq_val;
        SRC_C:    opnd[i] = c_r;
        SRC_H:    opnd[i] = h_r;
        SRC_RD:   opnd[i] = rd_r;
        SRC_RDS:  opnd[i] = rds_r;
        SRC_T0:   opnd[i] = t0_r;
        SRC_T1:   opnd[i] = t1_r;
        SRC_T2:   opnd[i] = t2_r;
        SRC_T3:   opnd[i] = t3_r;
        SRC_G:    opnd[i] = g_val;
        SRC_GM1:  opnd[i] = gm1_val;
        default:  opnd[i] = '0;
      endcase
    end
  end

  // rounded product, floor of (a*b + half) over one
  assign mres = (prod_r + FX_HALF) >>> FRACTION_BITS;

  always_comb begin
    operand = (uop.kind == K_MUL) ? mres : ACC_W'(opnd[0]);
    case (uop.aop)
      AOP_LD:   acc_nxt = operand;
      AOP_ADD:  acc_nxt = acc_r + operand;
      AOP_SUB:  acc_nxt = acc_r - operand;
      AOP_HNEG: acc_nxt = -(acc_r >>> 1);
      AOP_DBL:  acc_nxt = acc_r <<< 1;
      default:  acc_nxt = acc_r;
    endcase
    case (uop.kind)
      K_DIV:   value = ACC_W'(div_q);
      K_SQRT:  value = ACC_W'(root);
      default: value = acc_nxt;
    endcase
    clip = (value > MAX32) || (value < MIN32);
    if (value > MAX32) begin
      wval = 32'sh7fffffff;
    end else if (value < MIN32) begin
      wval = 32'sh80000000;
    end else begin
      wval = value[31:0];
    end
    case (uop.chk)
      CHK_LE0: chk_fail = (wval <= 0);
      CHK_EQ0: chk_fail = (wval == 0);
      default: chk_fail = 1'b0;
    endcase
  end

  assign dir_l = (in_data.command == CMD_LOAD) ? in_data.direction : sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
      sweep_r <= 1'b0;
      valid_r <= 1'b0;
      bad_r   <= 1'b0;
      clamp_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gamma_r <= cfg_wr_data;
      end
      if (cmd.latch) begin
        bad_r   <= 1'b0;
        clamp_r <= 1'b0;
        if (in_data.command == CMD_LOAD) begin
          sweep_r <= in_data.direction;
        end
      end else if (cmd.exec) begin
        if (chk_fail) begin
          bad_r <= 1'b1;
        end
        if (clip && uop.dst != DST_NONE) begin
          clamp_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        valid_r <= ~bad_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      q1_r <= in_data.density;
      qn_r <= dir_l ? in_data.momentum_y : in_data.momentum_x;
      qt_r <= dir_l ? in_data.momentum_x : in_data.momentum_y;
      qz_r <= in_data.momentum_z;
      q5_r <= in_data.total_energy;
    end
    if (cmd.mul_go) begin
      prod_r <= opnd[0] * opnd[1];
    end
    if (cmd.exec) begin
      if (uop.kind == K_MUL || uop.kind == K_ALU) begin
        acc_r <= acc_nxt;
      end
      case (uop.dst)
        DST_U1:  u1_r  <= wval;
        DST_U2:  u2_r  <= wval;
        DST_U3:  u3_r  <= wval;
        DST_Q2:  q2_r  <= wval;
        DST_C:   c_r   <= wval;
        DST_H:   h_r   <= wval;
        DST_RD:  rd_r  <= wval;
        DST_RDS: rds_r <= wval;
        DST_T0:  t0_r  <= wval;
        DST_T1:  t1_r  <= wval;
        DST_T2:  t2_r  <= wval;
        DST_T3:  t3_r  <= wval;
        DST_W1:  w1_r  <= wval;
        DST_W5:  w5_r  <= wval;
        DST_WE:  we_r  <= wval;
        DST_WT:  wt_r  <= wval;
        DST_WZ:  wz_r  <= wval;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      if (!valid_r) begin
        out_r.wave_first  <= '0;
        out_r.wave_second <= '0;
        out_r.wave_third  <= '0;
        out_r.wave_fourth <= '0;
        out_r.wave_fifth  <= '0;
        out_r.status      <= STATUS_INVALID;
      end else begin
        out_r.wave_first  <= w1_r;
        out_r.wave_second <= sweep_r ? wt_r : we_r;
        out_r.wave_third  <= sweep_r ? we_r : wt_r;
        out_r.wave_fourth <= wz_r;
        out_r.wave_fifth  <= w5_r;
        out_r.status      <= clamp_r ? STATUS_SATURATED : STATUS_OK;
      end
    end
  end

  eulp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.unit_go && uop.kind == K_DIV),
    .num   (opnd[0]),
    .den   (opnd[1]),
    .done  (div_done),
    .quot  (div_q)
  );

  eulp_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.unit_go && uop.kind == K_SQRT),
    .rad   (opnd[0]),
    .done  (sqrt_done),
    .root  (root)
  );

  assign sts.avg_valid = valid_r;
  assign sts.unit_done = div_done | sqrt_done;
  assign out_data      = out_r;

endmodule

/* src/eulp_ctrl.sv */
// controller: microprogram sequencer and handshake control
module eulp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_command,
  output logic           out_valid,
  input  logic           out_ready,
  input  eulp_pkg::sts_t sts,
  output eulp_pkg::cmd_t cmd
);
  import eulp_pkg::*;

  state_t            state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              load_r, load_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              step_done;
  uop_t              uop;

  assign uop = uop_rom(pc_r);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    load_nxt  = load_r;
    step_done = 1'b0;
    cmd       = '0;
    cmd.uop   = uop;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          load_nxt  = (in_command == CMD_LOAD);
          if (in_command == CMD_LOAD) begin
            pc_nxt    = LOAD_START;
            state_nxt = ST_ISSUE;
          end else if (!sts.avg_valid) begin
            state_nxt = ST_DONE;
          end else begin
            pc_nxt    = PROJ_START;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        unique case (uop.kind)
          K_ALU: begin
            cmd.exec  = 1'b1;
            step_done = 1'b1;
          end
          K_MUL: begin
            cmd.mul_go = 1'b1;
            state_nxt  = ST_MACC;
          end
          default: begin
            cmd.unit_go = 1'b1;
            state_nxt   = ST_UNIT;
          end
        endcase
      end
      ST_MACC: begin
        cmd.exec  = 1'b1;
        step_done = 1'b1;
      end
      ST_UNIT: begin
        if (sts.unit_done) begin
          cmd.exec  = 1'b1;
          step_done = 1'b1;
        end
      end
      ST_DONE: begin
        // output register frees up the same cycle its word is taken
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (step_done) begin
      if (uop.last) begin
        if (load_r) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end else begin
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_ISSUE;
      end
    end
    out_valid_nxt = (out_valid_r & ~out_ready) | cmd.out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      load_r      <= load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted word did not start work");

  a_unit_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.unit_done |-> (state_r == ST_UNIT))
    else $error("unit finished while controller was not waiting");

  a_mul_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE && uop.kind == K_MUL) |=> (state_r == ST_MACC))
    else $error("product issued without accumulate step");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word appeared outside of done state");
`endif

endmodule

/* sim/euler_left_eigen_projection_checker.sv */
// predictor and result checker for the euler left eigen projection block
module euler_left_eigen_projection_checker
  import eulp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_t                in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_t               out_data,
  input  logic               cfg_wr_en,
  input  logic [GAMMA_W-1:0] cfg_wr_data,
  output int                 error_count,
  output int                 waves_pending
);

  localparam longint ONE  = 64'sd65536;
  localparam longint HALF = 64'sd32768;

  // predicted copy of the block state
  longint gamma_q;
  logic   sweep_y;
  logic   avg_ok;
  longint vel_n, vel_t, vel_z, speed_sq, sound, enth, recip_d, recip_dc;
  logic   clipped;
  out_t   waves_expected[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF) >>> 16;
  endfunction

  function automatic longint qdiv(longint a, longint b);
    return (a * ONE) / b;
  endfunction

  function automatic longint root_floor(longint x);
    longint unsigned v, r, b;
    v = x;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic clear_average();
    vel_n = 0; vel_t = 0; vel_z = 0; speed_sq = 0; sound = 0; enth = 0;
    recip_d = 0; recip_dc = 0; avg_ok = 1'b0;
  endtask

  task automatic load_average(input in_t w);
    longint rho, mn, mt, mz, e, u1, u2, u3, q2, inner, p, a2, c, h, d, rd;
    rho = longint'(w.density);
    mn  = sweep_y ? longint'(w.momentum_y) : longint'(w.momentum_x);
    mt  = sweep_y ? longint'(w.momentum_x) : longint'(w.momentum_y);
    mz  = longint'(w.momentum_z);
    e   = longint'(w.total_energy);
    clear_average();
    if (rho <= 0) return;
    u1 = clamp32(qdiv(mn, rho));
    u2 = clamp32(qdiv(mt, rho));
    u3 = clamp32(qdiv(mz, rho));
    q2 = clamp32(qmul(u1, u1) + qmul(u2, u2) + qmul(u3, u3));
    inner = clamp32(e - (qmul(rho, q2) >>> 1));
    p = clamp32(qmul(gamma_q - ONE, inner));
    if (p <= 0) return;
    a2 = clamp32(qdiv(clamp32(qmul(gamma_q, p)), rho));
    if (a2 <= 0) return;
    c = root_floor(a2 <<< 16);
    h = clamp32(qdiv(clamp32(e + p), rho));
    d = clamp32(2 * h - q2);
    if (d == 0) return;
    rd = clamp32(qdiv(ONE, d));
    vel_n = u1; vel_t = u2; vel_z = u3; speed_sq = q2; sound = c; enth = h;
    recip_d = rd;
    recip_dc = clamp32(qdiv(rd, c));
    avg_ok = 1'b1;
  endtask

  function automatic out_t project_point(input in_t w);
    out_t   r;
    longint q1, qn, qt, qz, q5, hq, uc, hu, s, cs, a1, b1, a5, b5, n1, n5, n2;
    longint w1, w5, we, wt, wz;
    clipped = 1'b0;
    q1 = longint'(w.density);
    qn = sweep_y ? longint'(w.momentum_y) : longint'(w.momentum_x);
    qt = sweep_y ? longint'(w.momentum_x) : longint'(w.momentum_y);
    qz = longint'(w.momentum_z);
    q5 = longint'(w.total_energy);
    hq = speed_sq >>> 1;
    uc = qmul(vel_n, sound);
    hu = qmul(enth, vel_n);
    s  = clamp32(q5 - qmul(vel_t, qt) - qmul(vel_z, qz));
    cs = qmul(sound, s);
    a1 = clamp32(hq - enth - uc);
    b1 = clamp32(qmul(hq, clamp32(sound - vel_n)) + hu);
    n1 = clamp32(qmul(a1, qn) + qmul(b1, q1) + cs);
    w1 = clamp32(qmul(n1, recip_dc));
    a5 = clamp32(enth - hq - uc);
    b5 = clamp32(qmul(hq, clamp32(sound + vel_n)) - hu);
    n5 = clamp32(qmul(a5, qn) + qmul(b5, q1) + cs);
    w5 = clamp32(qmul(n5, recip_dc));
    n2 = clamp32(qmul(clamp32(enth - speed_sq), q1) + qmul(vel_n, qn)
                 + qmul(vel_t, qt) + qmul(vel_z, qz) - q5);
    we = clamp32(2 * qmul(n2, recip_d));
    wt = clamp32(qt - qmul(vel_t, q1));
    wz = clamp32(qz - qmul(vel_z, q1));
    r.wave_first  = w1[31:0];
    r.wave_second = sweep_y ? wt[31:0] : we[31:0];
    r.wave_third  = sweep_y ? we[31:0] : wt[31:0];
    r.wave_fourth = wz[31:0];
    r.wave_fifth  = w5[31:0];
    r.status      = clipped ? STATUS_SATURATED : STATUS_OK;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v),
             $signed(act_v));
      error_count++;
    end
  endtask

  assign waves_pending = waves_expected.size();

  initial error_count = 0;

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      gamma_q = 91750;
      sweep_y = 1'b0;
      clear_average();
      waves_expected.delete();
    end else begin
      if (cfg_wr_en) gamma_q = longint'(cfg_wr_data);
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_LOAD) begin
          sweep_y = in_data.direction;
          load_average(in_data);
        end else if (!avg_ok) begin
          want = '0;
          want.status = STATUS_INVALID;
          waves_expected.push_back(want);
        end else begin
          waves_expected.push_back(project_point(in_data));
        end
      end
      if (out_valid && out_ready) begin
        if (waves_expected.size() == 0) begin
          $error("result word with no expectation waiting");
          error_count++;
        end else begin
          want = waves_expected.pop_front();
          compare_field("wave_first", want.wave_first, out_data.wave_first);
          compare_field("wave_second", want.wave_second, out_data.wave_second);
          compare_field("wave_third", want.wave_third, out_data.wave_third);
          compare_field("wave_fourth", want.wave_fourth, out_data.wave_fourth);
          compare_field("wave_fifth", want.wave_fifth, out_data.wave_fifth);
          compare_field("status", 32'(want.status), 32'(out_data.status));
        end
      end
    end
  end

endmodule

/* sim/euler_left_eigen_projection_tb.sv */
// stimulus, reset and verdict for the euler left eigen projection block
module euler_left_eigen_projection_tb;
  import eulp_pkg::*;

  localparam int LOAD_SETTLE = 450;
  localparam int STALL_LIMIT = 6000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;
  logic               cfg_wr_en;
  logic [GAMMA_W-1:0] cfg_wr_data;
  int                 error_count;
  int                 waves_pending;
  int                 words_sent;
  int                 idle_mode;
  int                 quiet_cycles;

  euler_left_eigen_projection u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  euler_left_eigen_projection_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .error_count  (error_count),
    .waves_pending(waves_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_t make_word(logic cmd, logic dir, int rho, int mx, int my,
                                    int mz, int e);
    in_t w;
    w.command      = cmd;
    w.direction    = dir;
    w.density      = rho;
    w.momentum_x   = mx;
    w.momentum_y   = my;
    w.momentum_z   = mz;
    w.total_energy = e;
    return w;
  endfunction

  function automatic int small_signed(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // plausible gas state: positive density, modest momenta, enough energy
  function automatic in_t sane_load(logic dir);
    return make_word(CMD_LOAD, dir, $urandom_range(32768, 524288),
                     small_signed(131072), small_signed(131072),
                     small_signed(131072), $urandom_range(1 << 21, 1 << 24));
  endfunction

  function automatic in_t wild_word(logic cmd);
    return make_word(cmd, $urandom_range(1), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
  endfunction

  function automatic in_t point_word();
    if ($urandom_range(9) == 0) return wild_word(CMD_PROJECT);
    return make_word(CMD_PROJECT, $urandom_range(1), small_signed(1 << 22),
                     small_signed(1 << 22), small_signed(1 << 22),
                     small_signed(1 << 22), small_signed(1 << 24));
  endfunction

  // called at a rising edge; returns at the edge that takes the word, unless it then drops in_valid and idles at random
  task automatic send_word(input in_t w);
    logic took;
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    words_sent++;
    if ((idle_mode == 0 && $urandom_range(99) < 8) ||
        (idle_mode == 1 && $urandom_range(99) < 84)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // gamma changes only once every result is back and any load has finished
  task automatic write_gamma(input logic [GAMMA_W-1:0] g);
    in_valid <= 1'b0;
    do @(negedge clk); while (waves_pending != 0);
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: random stalls per phase and one long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= 700) begin
        held = 1'b1;
        hold_left = 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_mode == 0) begin
        out_ready <= ($urandom_range(99) >= 84);
      end else if (idle_mode == 1) begin
        out_ready <= ($urandom_range(99) >= 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n;
    logic dir;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    words_sent  = 0;
    idle_mode   = 0;
    rst_n       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: invalid averages, extremes, both sweeps
    send_word(make_word(CMD_PROJECT, 1'b0, 65536, 0, 0, 0, 65536));
    send_word(make_word(CMD_LOAD, 1'b0, 0, 65536, 0, 0, 1 << 20));
    send_word(make_word(CMD_PROJECT, 1'b1, 65536, 1, 2, 3, 4));
    send_word(make_word(CMD_LOAD, 1'b1, -65536, 0, 0, 0, 1 << 20));
    send_word(make_word(CMD_PROJECT, 1'b0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_LOAD, 1'b0, 65536, 65536, 0, 0, 0));
    send_word(make_word(CMD_PROJECT, 1'b0, 65536, 65536, 0, 0, 65536));
    send_word(make_word(CMD_LOAD, 1'b0, 65536, 32768, -16384, 8192, 3 << 17));
    send_word(make_word(CMD_PROJECT, 1'b0, 65536, 32768, -16384, 8192, 3 << 17));
    send_word(make_word(CMD_PROJECT, 1'b1, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_word(make_word(CMD_PROJECT, 1'b0, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000));
    send_word(make_word(CMD_PROJECT, 1'b0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_LOAD, 1'b1, 131072, -65536, 98304, 0, 1 << 21));
    send_word(make_word(CMD_PROJECT, 1'b0, 65536, 1 << 18, -(1 << 18), 7, -5));
    send_word(make_word(CMD_PROJECT, 1'b1, 32'h7fffffff, 32'h80000000, 0,
                        32'h7fffffff, 32'h80000000));
    send_word(make_word(CMD_LOAD, 1'b0, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send_word(make_word(CMD_PROJECT, 1'b0, 65536, 65536, 65536, 65536, 65536));
    send_word(make_word(CMD_LOAD, 1'b1, 1, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff));
    send_word(make_word(CMD_PROJECT, 1'b1, 65536, 65536, 65536, 65536, 65536));

    write_gamma(18'd196608);
    send_word(make_word(CMD_LOAD, 1'b0, 65536, 32768, -16384, 8192, 3 << 17));
    send_word(make_word(CMD_PROJECT, 1'b0, 65536, 32768, -16384, 8192, 3 << 17));

    // random: a load then a run of points, with some noise words
    while (words_sent < 960) begin
      if (idle_mode == 0 && words_sent >= 330) begin
        write_gamma(18'd65537);
        idle_mode = 1;
      end else if (idle_mode == 1 && words_sent >= 640) begin
        write_gamma(GAMMA_W'($urandom_range(65537, 196608)));
        idle_mode = 2;
      end
      dir = $urandom_range(1);
      if ($urandom_range(9) == 0) send_word(wild_word(CMD_LOAD));
      else send_word(sane_load(dir));
      n = $urandom_range(1, 8);
      repeat (n) send_word(point_word());
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (waves_pending != 0);
    repeat (LOAD_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
